FILE: src/mbc_pkg.sv
// Shared types, constants and helpers of the MIDI beat clock generator.
`default_nettype none
package mbc_pkg;

    localparam int ACTION_W   = 3;
    localparam int NOW_W      = 48;
    localparam int REQ_W      = 18;
    localparam int TEMPO_W    = 17;
    localparam int INTERVAL_W = 48;
    localparam int NEXT_W     = 64;
    localparam int MSG_W      = 8;
    localparam int US_W       = 28;   // bits of the per-beat constant below

    localparam int FRAC_BITS_DFLT = 16;
    localparam int MAX_TICKS_DFLT = 32;

    localparam logic [63:0]              US_PER_BEAT_CENTI = 64'd250000000;
    localparam logic [TEMPO_W-1:0]       TEMPO_DEFAULT     = 17'd12000;
    localparam logic signed [REQ_W-1:0]  REQ_MIN           = 18'sd100;
    localparam logic signed [REQ_W-1:0]  REQ_MAX           = 18'sd99900;

    localparam logic [MSG_W-1:0] RT_CLOCK    = 8'hF8;
    localparam logic [MSG_W-1:0] RT_START    = 8'hFA;
    localparam logic [MSG_W-1:0] RT_CONTINUE = 8'hFB;
    localparam logic [MSG_W-1:0] RT_STOP     = 8'hFC;

    typedef enum logic [ACTION_W-1:0] {
        ACT_UPDATE    = 3'd0,
        ACT_START     = 3'd1,
        ACT_STOP      = 3'd2,
        ACT_RESUME    = 3'd3,
        ACT_SET_TEMPO = 3'd4
    } t_action;

    // Controller to datapath.
    typedef struct packed {
        logic             tempo_load;
        logic             tempo_dflt;
        logic             run_set;
        logic             run_clr;
        logic             ever_set;
        logic             next_from_now;
        logic             loop_init;
        logic             div_start;
        logic             interval_load;
        logic             tick_adv;
        logic             emit;
        logic [MSG_W-1:0] emit_byte;
        logic             emit_last;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic running;
        logic ever_started;
        logic req_pos;
        logic due;
        logic pend;
        logic out_free;
        logic div_done;
    } t_status;

    function automatic logic [TEMPO_W-1:0] clamp_tempo(input logic signed [REQ_W-1:0] req);
        logic signed [REQ_W-1:0] t;
        t = req;
        if (t < REQ_MIN) begin
            t = REQ_MIN;
        end
        if (t > REQ_MAX) begin
            t = REQ_MAX;
        end
        return t[TEMPO_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/mbc_div.sv
// Bit-serial restoring divider: per-beat constant divided by the tempo.
`default_nettype none
module mbc_div #(
    parameter int FRAC_BITS = mbc_pkg::FRAC_BITS_DFLT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic [mbc_pkg::TEMPO_W-1:0]           i_divisor,
    output logic                                       o_done,
    output logic [mbc_pkg::US_W+FRAC_BITS-1:0]         o_quotient
);
    import mbc_pkg::*;

    localparam int DVD_W = US_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(US_PER_BEAT_CENTI << FRAC_BITS);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [TEMPO_W-1:0] r_rem;
    logic [DVD_W-1:0]   r_quo;

    logic [TEMPO_W:0]   rem_sh;
    logic [TEMPO_W:0]   rem_sub;
    logic               ge;

    assign rem_sh  = {r_rem, r_quo[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, i_divisor};
    assign ge      = rem_sh >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle, dividend shifted in from the top.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= DIVIDEND;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[TEMPO_W-1:0] : rem_sh[TEMPO_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

FILE: src/mbc_datapath.sv
// Datapath: tempo, interval, next tick time, tick loop counter and output register.
`default_nettype none
module mbc_datapath #(
    parameter int MAX_TICKS_PER_UPDATE = mbc_pkg::MAX_TICKS_DFLT,
    parameter int FRAC_BITS            = mbc_pkg::FRAC_BITS_DFLT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [mbc_pkg::NOW_W-1:0]         i_now_us,
    input  wire logic signed [mbc_pkg::REQ_W-1:0]  i_tempo_centi,
    input  wire mbc_pkg::t_cmd                     i_cmd,
    input  wire logic                              i_stall,
    output mbc_pkg::t_status                       o_status,
    output logic                                   o_valid,
    output logic [mbc_pkg::MSG_W-1:0]              o_message_byte,
    output logic                                   o_last
);
    import mbc_pkg::*;

    localparam int DVD_W = US_W + FRAC_BITS;
    localparam int CNT_W = $clog2(MAX_TICKS_PER_UPDATE + 1);
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST =
        INTERVAL_W'((US_PER_BEAT_CENTI << FRAC_BITS) / 64'(TEMPO_DEFAULT));

    logic                  r_running;
    logic                  r_ever;
    logic [TEMPO_W-1:0]    r_tempo;
    logic [INTERVAL_W-1:0] r_interval;
    logic [NEXT_W-1:0]     r_next;
    logic [NEXT_W-1:0]     r_nowq;
    logic [CNT_W-1:0]      r_count;
    logic                  r_pend;
    logic                  r_ov;
    logic [MSG_W-1:0]      r_byte;
    logic                  r_last;

    logic                  div_done;
    logic [DVD_W-1:0]      div_quo;
    logic [NEXT_W:0]       sum;
    logic [NEXT_W-1:0]     next_adv;
    logic [NEXT_W-1:0]     now_q;
    logic                  due;
    logic                  out_free;

    mbc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (r_tempo),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign now_q    = NEXT_W'(i_now_us) << FRAC_BITS;
    assign sum      = {1'b0, r_next} + (NEXT_W + 1)'(r_interval);
    assign next_adv = sum[NEXT_W] ? '1 : sum[NEXT_W-1:0];   // saturate, never wrap
    assign due      = (r_count < CNT_W'(MAX_TICKS_PER_UPDATE)) && (r_nowq >= r_next);
    assign out_free = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_ever     <= 1'b0;
            r_tempo    <= TEMPO_DEFAULT;
            r_interval <= INTERVAL_RST;
            r_next     <= '0;
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cmd.tempo_load) begin
                r_tempo <= i_cmd.tempo_dflt ? TEMPO_DEFAULT : clamp_tempo(i_tempo_centi);
            end
            if (i_cmd.run_set) begin
                r_running <= 1'b1;
            end else if (i_cmd.run_clr) begin
                r_running <= 1'b0;
            end
            if (i_cmd.ever_set) begin
                r_ever <= 1'b1;
            end
            if (i_cmd.interval_load) begin
                r_interval <= INTERVAL_W'(div_quo);
            end
            if (i_cmd.next_from_now) begin
                r_next <= now_q;
            end else if (i_cmd.tick_adv) begin
                r_next <= next_adv;
            end
            if (i_cmd.loop_init) begin
                r_count <= '0;
                r_pend  <= 1'b0;
            end else if (i_cmd.tick_adv) begin
                r_count <= r_count + CNT_W'(1);
                r_pend  <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.loop_init) begin
            r_nowq <= now_q;
        end
        if (i_cmd.emit) begin
            r_byte <= i_cmd.emit_byte;
            r_last <= i_cmd.emit_last;
        end
    end

    always_comb begin
        o_status.running      = r_running;
        o_status.ever_started = r_ever;
        o_status.req_pos      = i_tempo_centi > 18'sd0;
        o_status.due          = due;
        o_status.pend         = r_pend;
        o_status.out_free     = out_free;
        o_status.div_done     = div_done;
    end

    assign o_valid        = r_ov;
    assign o_message_byte = r_byte;
    assign o_last         = r_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("item loaded over an untaken result");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TICKS_PER_UPDATE))
        else $error("tick count beyond per-update limit");

    a_run_ever: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> r_ever)
        else $error("running without any start");

    a_next_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_adv && !i_cmd.next_from_now |=> r_next >= $past(r_next))
        else $error("next tick time moved backward");

endmodule
`default_nettype wire

FILE: src/mbc_ctrl.sv
// Controller: command decode and sequencing of divider, tick loop and emission.
`default_nettype none
module mbc_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [mbc_pkg::ACTION_W-1:0]  i_action,
    input  wire mbc_pkg::t_status              i_status,
    output logic                               o_stall,
    output mbc_pkg::t_cmd                      o_cmd
);
    import mbc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIVGO = 5'b00010,
        ST_DIVW  = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_TEST  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [MSG_W-1:0] r_msg, n_msg;
    logic             r_has_msg, n_has_msg;
    logic             accept;

    assign o_stall = r_state != ST_IDLE;
    assign accept  = i_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_msg     = r_msg;
        n_has_msg = r_has_msg;
        o_cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (t_action'(i_action))
                        ACT_UPDATE: begin
                            o_cmd.loop_init = 1'b1;
                            if (i_status.running) begin
                                n_state = ST_TEST;
                            end
                        end
                        ACT_START: begin
                            o_cmd.tempo_load    = 1'b1;
                            o_cmd.tempo_dflt    = !i_status.req_pos;
                            o_cmd.run_set       = 1'b1;
                            o_cmd.ever_set      = 1'b1;
                            o_cmd.next_from_now = 1'b1;
                            n_msg               = RT_START;
                            n_has_msg           = 1'b1;
                            n_state             = ST_DIVGO;
                        end
                        ACT_STOP: begin
                            if (i_status.running) begin
                                o_cmd.run_clr = 1'b1;
                                n_msg         = RT_STOP;
                                n_state       = ST_EMIT;
                            end
                        end
                        ACT_RESUME: begin
                            // Held tempo and interval always agree, so no divide.
                            if (!i_status.running) begin
                                o_cmd.run_set       = 1'b1;
                                o_cmd.ever_set      = 1'b1;
                                o_cmd.next_from_now = 1'b1;
                                n_msg   = i_status.ever_started ? RT_CONTINUE : RT_START;
                                n_state = ST_EMIT;
                            end
                        end
                        ACT_SET_TEMPO: begin
                            if (i_status.req_pos) begin
                                o_cmd.tempo_load = 1'b1;
                                n_has_msg        = 1'b0;
                                n_state          = ST_DIVGO;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIVW;
            end
            ST_DIVW: begin
                if (i_status.div_done) begin
                    o_cmd.interval_load = 1'b1;
                    n_state = r_has_msg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_byte = r_msg;
                    o_cmd.emit_last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_TEST: begin
                // One tick is held back until we know whether another follows.
                if (i_status.out_free) begin
                    if (i_status.due) begin
                        o_cmd.tick_adv = 1'b1;
                        if (i_status.pend) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_byte = RT_CLOCK;
                            o_cmd.emit_last = 1'b0;
                        end
                    end else begin
                        if (i_status.pend) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_byte = RT_CLOCK;
                            o_cmd.emit_last = 1'b1;
                        end
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_has_msg <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_has_msg <= n_has_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg <= n_msg;
    end

endmodule
`default_nettype wire

FILE: src/midi_beat_clock_generator.sv
// Top level of the MIDI beat clock generator.
`default_nettype none
// Each input item is a command (update, start, stop, resume, set tempo) with a
// microsecond timestamp and a requested tempo in hundredths of BPM. The block
// answers with zero or more MIDI realtime bytes; o_last marks the final byte an
// item produces. Start and set tempo recompute the Q(FRAC_BITS) tick interval
// with a bit-serial divider that takes one quotient bit per cycle, and the
// block takes no new item until the divide is done and any start byte is
// loaded. A running update emits one clock byte per due tick, up to
// MAX_TICKS_PER_UPDATE bytes; the tick loop compares and advances the 64-bit
// next-tick time once per cycle while the output register is free. Results sit
// in an output register that a stalled consumer holds, and the tick loop and
// emits wait for it. Ticks step the next-tick time by exactly one interval,
// saturating at all ones, so timing does not drift.
module midi_beat_clock_generator #(
    parameter int MAX_TICKS_PER_UPDATE = mbc_pkg::MAX_TICKS_DFLT,
    parameter int FRAC_BITS            = mbc_pkg::FRAC_BITS_DFLT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [mbc_pkg::ACTION_W-1:0]      i_action,
    input  wire logic [mbc_pkg::NOW_W-1:0]         i_now_us,
    input  wire logic signed [mbc_pkg::REQ_W-1:0]  i_tempo_centi,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [mbc_pkg::MSG_W-1:0]              o_message_byte,
    output logic                                   o_last
);
    import mbc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence each item: decode, divide, tick loop, emit.
    mbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    // Hold tempo, interval and timing state; drive the result register.
    mbc_datapath #(
        .MAX_TICKS_PER_UPDATE (MAX_TICKS_PER_UPDATE),
        .FRAC_BITS            (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_now_us       (i_now_us),
        .i_tempo_centi  (i_tempo_centi),
        .i_cmd          (cmd),
        .i_stall        (i_stall),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_message_byte (o_message_byte),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

FILE: tb/midi_beat_clock_generator_test.sv
// Self-checking testbench of the MIDI beat clock generator: directed and random commands.
module midi_beat_clock_generator_test;
    import mbc_pkg::*;

    // Widths and limits of the block as built here (default parameters).
    localparam int FRAC      = FRAC_BITS_DFLT;
    localparam int MAX_TICKS = MAX_TICKS_DFLT;

    // Stimulus shape: random item count, the stretch run without any idling,
    // and the share of cycles in which each side idles.
    localparam int RANDOM_ITEMS = 204;
    localparam int STEADY_FIRST = 80;
    localparam int STEADY_LAST  = 140;
    localparam int IDLE_PCT     = 31;

    // The longest legal quiet stretch is a tempo divide plus a run of output
    // stalls; allow far more before declaring a hang.
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;

    // Action codes the block does not define; it must ignore them.
    localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;
    localparam logic [NOW_W-1:0]    NOW_MAX         = '1;

    typedef struct packed {
        logic [MSG_W-1:0] msg;
        logic             last;
    } t_beat_msg;

    // Beat clock predictor plus the queue of bytes it says are still owed.
    class t_beat_scoreboard;
        bit                    running;
        bit                    ever_started;
        logic [TEMPO_W-1:0]    tempo;
        logic [INTERVAL_W-1:0] interval;
        logic [NEXT_W-1:0]     next_tick;
        t_beat_msg             due_msgs[$];
        int unsigned           mismatches;

        function new();
            running      = 1'b0;
            ever_started = 1'b0;
            tempo        = TEMPO_DEFAULT;
            next_tick    = '0;
            mismatches   = 0;
            retime();
        endfunction

        // Tick interval in Q(FRAC) microseconds, truncating division.
        function void retime();
            logic [63:0] divisor;
            divisor  = (tempo != '0) ? 64'(tempo) : 64'(TEMPO_DEFAULT);
            interval = INTERVAL_W'((US_PER_BEAT_CENTI << FRAC) / divisor);
        endfunction

        function logic [TEMPO_W-1:0] clamp_centi(logic signed [REQ_W-1:0] req);
            if (req < REQ_MIN) return TEMPO_W'(REQ_MIN);
            if (req > REQ_MAX) return TEMPO_W'(REQ_MAX);
            return TEMPO_W'(req);
        endfunction

        function void push_msg(logic [MSG_W-1:0] m);
            due_msgs.push_back('{msg: m, last: 1'b0});
        endfunction

        function void start_run(logic [NOW_W-1:0] now);
            running      = 1'b1;
            ever_started = 1'b1;
            retime();
            next_tick    = NEXT_W'(now) << FRAC;
            push_msg(RT_START);
        endfunction

        // Apply one accepted item and queue the bytes it owes.
        function void note_item(logic [ACTION_W-1:0] action, logic [NOW_W-1:0] now,
                                logic signed [REQ_W-1:0] req);
            int               owed_before;
            logic [NEXT_W-1:0] now_q;
            owed_before = due_msgs.size();
            now_q       = NEXT_W'(now) << FRAC;
            case (action)
                ACT_UPDATE: begin
                    if (running) begin
                        for (int k = 0; k < MAX_TICKS && now_q >= next_tick; k++) begin
                            push_msg(RT_CLOCK);
                            // saturate rather than wrap near the top of time
                            if (next_tick > ~NEXT_W'(interval)) begin
                                next_tick = '1;
                            end else begin
                                next_tick = next_tick + NEXT_W'(interval);
                            end
                        end
                    end
                end
                ACT_START: begin
                    tempo = (req <= 0) ? TEMPO_DEFAULT : clamp_centi(req);
                    start_run(now);
                end
                ACT_STOP: begin
                    if (running) begin
                        running = 1'b0;
                        push_msg(RT_STOP);
                    end
                end
                ACT_RESUME: begin
                    if (!running) begin
                        if (!ever_started) begin
                            start_run(now);
                        end else begin
                            running   = 1'b1;
                            next_tick = now_q;
                            push_msg(RT_CONTINUE);
                        end
                    end
                end
                ACT_SET_TEMPO: begin
                    if (req > 0) begin
                        tempo = clamp_centi(req);
                        retime();
                    end
                end
                default: begin
                end
            endcase
            if (due_msgs.size() > owed_before) begin
                due_msgs[due_msgs.size() - 1].last = 1'b1;
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH: %s", what);
            end
        endfunction

        // Compare one delivered byte against the oldest owed one.
        function void check_result(logic [MSG_W-1:0] msg, logic last);
            t_beat_msg want;
            if (due_msgs.size() == 0) begin
                flag($sformatf("unexpected byte %h last %b", msg, last));
            end else begin
                want = due_msgs.pop_front();
                if (want.msg !== msg || want.last !== last) begin
                    flag($sformatf("byte expected %h got %h, last expected %b got %b",
                                   want.msg, msg, want.last, last));
                end
            end
        endfunction
    endclass

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      i_stall       = 1'b0;
    logic [ACTION_W-1:0]       i_action      = ACT_UPDATE;
    logic [NOW_W-1:0]          i_now_us      = '0;
    logic signed [REQ_W-1:0]   i_tempo_centi = '0;
    logic                      o_stall;
    logic                      o_valid;
    logic [MSG_W-1:0]          o_message_byte;
    logic                      o_last;

    t_beat_scoreboard sb = new();

    int unsigned      quiet_cycles = 0;  // cycles since anything was accepted
    bit               steady       = 1'b0;  // no idling on either side while set
    logic [31:0]      tick_us      = 32'd20833;  // whole microseconds per tick, for stimulus
    logic [NOW_W-1:0] song_us;                   // stimulus time base

    midi_beat_clock_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_now_us       (i_now_us),
        .i_tempo_centi  (i_tempo_centi),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_message_byte (o_message_byte),
        .o_last         (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Stall the result side at random, except through the steady stretch.
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watch both handshakes at every edge: predict on an accepted item first,
    // then check an accepted result, all in this one process so their order
    // within the edge is fixed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                sb.note_item(i_action, i_now_us, i_tempo_centi);
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_message_byte, o_last);
            end
            quiet_cycles <= ((i_valid && !o_stall) || (o_valid && !i_stall)) ? 0
                                                                             : quiet_cycles + 1;
            // publish the tick length for the stimulus; the NBA keeps the read order fixed
            tick_us <= 32'(sb.interval >> FRAC);
        end
    end

    // Hang guard: too long with no handshake on either side ends the run.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Present one item, hold it until accepted, then idle at random.
    task automatic send_item(input logic [ACTION_W-1:0] action, input logic [NOW_W-1:0] now,
                             input logic signed [REQ_W-1:0] req);
        i_valid       <= 1'b1;
        i_action      <= action;
        i_now_us      <= now;
        i_tempo_centi <= req;
        do @(posedge i_clk); while (o_stall);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [NOW_W-1:0] rand_now();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly legal tempos, some out of range, some zero or negative.
    function automatic logic signed [REQ_W-1:0] pick_tempo();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return REQ_W'($urandom_range(100, 99900));
        if (r < 80) return REQ_W'($urandom);
        return REQ_W'(-int'($urandom_range(0, 131072)));
    endfunction

    // Move the time base forward by up to the given number of ticks.
    function automatic logic [NOW_W-1:0] advance(int unsigned span_ticks);
        song_us = song_us + NOW_W'($urandom_range(0, span_ticks * tick_us));
        return song_us;
    endfunction

    initial begin
        int               r;
        int               pick;
        int               sent;
        logic [NOW_W-1:0] now;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Nothing runs yet: update and stop must stay silent.
        send_item(ACT_UPDATE, 48'd0, '0);
        send_item(ACT_STOP, 48'd0, '0);
        // Resume before any start behaves as a start at the held tempo.
        send_item(ACT_RESUME, 48'd1000, '0);
        send_item(ACT_RESUME, 48'd1500, '0);
        // First clock is due at once, the second one interval later.
        send_item(ACT_UPDATE, 48'd1000, '0);
        send_item(ACT_UPDATE, 48'd22000, '0);
        // Zero and negative tempos are dropped; others clamp to both ends.
        send_item(ACT_SET_TEMPO, 48'd0, '0);
        send_item(ACT_SET_TEMPO, 48'd0, -18'sd1);
        send_item(ACT_SET_TEMPO, 48'd0, 18'sd50);
        send_item(ACT_SET_TEMPO, 48'd0, 18'sh1FFFF);
        // Far ahead: the first update caps at the per-update limit, the next drains on.
        send_item(ACT_UPDATE, 48'd2000000, '0);
        send_item(ACT_UPDATE, 48'd2000000, '0);
        send_item(ACT_STOP, 48'd2000000, '0);
        send_item(ACT_STOP, 48'd2000000, '0);
        send_item(ACT_UPDATE, 48'd3000000, '0);
        send_item(ACT_RESUME, 48'd3000000, '0);
        // Start tempo: zero and most negative take the default, then both clamps.
        send_item(ACT_START, 48'd3100000, 18'sd0);
        send_item(ACT_START, 48'd3200000, 18'sh20000);
        send_item(ACT_START, 48'd3300000, 18'sd1);
        send_item(ACT_START, 48'd3400000, 18'sd99901);
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++) begin
            send_item(ACTION_W'(a), NOW_MAX, 18'sh1FFFF);
        end
        // Start at the top of time: one clock, then the next tick saturates.
        send_item(ACT_START, NOW_MAX, 18'sd12000);
        send_item(ACT_UPDATE, NOW_MAX, -18'sd1);
        send_item(ACT_UPDATE, NOW_MAX, '0);

        // Random part: mostly updates on a running clock with a moving time base,
        // mixed with commands, junk in unused fields and the odd jump in time.
        song_us = 48'd5000000;
        sent    = 0;
        while (sent < RANDOM_ITEMS) begin
            steady <= (sent >= STEADY_FIRST && sent < STEADY_LAST);
            r = $urandom_range(0, 99);
            if (r < 58) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    now = song_us;
                end else if (pick < 80) begin
                    now = advance(3);
                end else if (pick < 95) begin
                    now = advance(40);
                end else begin
                    song_us = rand_now();
                    now     = song_us;
                end
                send_item(ACT_UPDATE, now, pick_tempo());
            end else if (r < 66) begin
                if ($urandom_range(0, 9) == 0) begin
                    song_us = rand_now();
                end
                send_item(ACT_START, advance(1), pick_tempo());
            end else if (r < 74) begin
                send_item(ACT_STOP, rand_now(), pick_tempo());
            end else if (r < 82) begin
                send_item(ACT_RESUME, advance(1), pick_tempo());
            end else if (r < 95) begin
                send_item(ACT_SET_TEMPO, rand_now(), pick_tempo());
            end else begin
                send_item(ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)),
                          rand_now(), pick_tempo());
            end
            sent++;
        end
        steady  <= 1'b0;
        i_valid <= 1'b0;

        // Drain: wait for every owed byte, then watch a while for strays.
        while (sb.due_msgs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
